### hdl/aes_pkg.sv
// aes-128 shared constants and byte functions
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

    localparam int KEY_WORDS = 4;
    localparam int RCON_INIT = 8'h01;

    // round operation codes for the round unit
    typedef enum logic [1:0] {
        OP_ADD_ONLY  = 2'd0,
        OP_FULL      = 2'd1,
        OP_LAST      = 2'd2
    } round_op_t;

    // multiply by two in gf(2^8) under 0x11b
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // small constant multiplies built from xtime
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        gmul = (b[0] ? a : 8'h00) ^ (b[1] ? x2 : 8'h00) ^
               (b[2] ? x4 : 8'h00) ^ (b[3] ? x8 : 8'h00);
    endfunction

    // forward s-box, constant table
    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    // inverse s-box, constant table
    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sbox = t[x];
    endfunction

    // one column through mixcolumns or invmixcolumns
    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inverse);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        if (!inverse) begin
            mix_col = {gmul(a0, 4'd2) ^ gmul(a1, 4'd3) ^ a2 ^ a3,
                       a0 ^ gmul(a1, 4'd2) ^ gmul(a2, 4'd3) ^ a3,
                       a0 ^ a1 ^ gmul(a2, 4'd2) ^ gmul(a3, 4'd3),
                       gmul(a0, 4'd3) ^ a1 ^ a2 ^ gmul(a3, 4'd2)};
        end else begin
            mix_col = {gmul(a0, 4'hE) ^ gmul(a1, 4'hB) ^ gmul(a2, 4'hD) ^ gmul(a3, 4'h9),
                       gmul(a0, 4'h9) ^ gmul(a1, 4'hE) ^ gmul(a2, 4'hB) ^ gmul(a3, 4'hD),
                       gmul(a0, 4'hD) ^ gmul(a1, 4'h9) ^ gmul(a2, 4'hE) ^ gmul(a3, 4'hB),
                       gmul(a0, 4'hB) ^ gmul(a1, 4'hD) ^ gmul(a2, 4'h9) ^ gmul(a3, 4'hE)};
        end
    endfunction

endpackage
`default_nettype wire

### hdl/aes_key_sched.sv
// round key schedule: one word per cycle into a key memory
`timescale 1ns / 1ps
`default_nettype none
module aes_key_sched
    import aes_pkg::*;
#(
    parameter int ROUND_COUNT = 10
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [127:0]  key,
    input  wire logic [$clog2(4*(ROUND_COUNT+1))-1:0] rd_addr,
    output logic [31:0]        rd_data,
    output logic               busy
);
    localparam int WORDS = 4 * (ROUND_COUNT + 1);
    localparam int AW = $clog2(WORDS);

    logic [31:0] mem [WORDS];
    logic [31:0] w_reg [KEY_WORDS];
    logic [AW:0] idx_reg;
    logic [7:0]  rcon_reg;
    logic        busy_reg;
    logic [31:0] t, nw;

    // next schedule word from the last four
    always_comb begin
        t = w_reg[3];
        if (idx_reg[1:0] == 2'd0) begin
            t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])}
                ^ {rcon_reg, 24'h0};
        end
        nw = w_reg[0] ^ t;
    end

    // sequencer and memory write; the key words go in first, one per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            rcon_reg <= 8'(RCON_INIT);
        end else if (start) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            rcon_reg <= 8'(RCON_INIT);
            w_reg[0] <= key[127:96];
            w_reg[1] <= key[95:64];
            w_reg[2] <= key[63:32];
            w_reg[3] <= key[31:0];
        end else if (busy_reg) begin
            if (idx_reg < (AW+1)'(KEY_WORDS)) begin
                // rotate the key words through the write port
                mem[idx_reg[AW-1:0]] <= w_reg[0];
                w_reg[0] <= w_reg[1];
                w_reg[1] <= w_reg[2];
                w_reg[2] <= w_reg[3];
                w_reg[3] <= w_reg[0];
            end else begin
                mem[idx_reg[AW-1:0]] <= nw;
                w_reg[0] <= w_reg[1];
                w_reg[1] <= w_reg[2];
                w_reg[2] <= w_reg[3];
                w_reg[3] <= nw;
                if (idx_reg[1:0] == 2'd0) rcon_reg <= xtime(rcon_reg);
            end
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == (AW+1)'(WORDS - 1)) busy_reg <= 1'b0;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

    assign busy = busy_reg;
endmodule
`default_nettype wire

### hdl/aes_round.sv
// one aes round, forward or inverse, shared over all rounds
`timescale 1ns / 1ps
`default_nettype none
module aes_round
    import aes_pkg::*;
(
    input  wire logic [127:0] state_in,
    input  wire logic [127:0] round_key,
    input  wire logic         inverse,
    input  wire round_op_t    op,
    output logic [127:0]      state_out
);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] sh, mx, k;

    // substitute and shift rows; byte c*4+r sits at bits 127-8*(c*4+r)
    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = state_in[127-8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (!inverse) t[c*4+r] = sbox(s[((c+r)%4)*4+r]);
                else          t[((c+r)%4)*4+r] = inv_sbox(s[c*4+r]);
            end
        end
        for (int i = 0; i < 16; i++) sh[127-8*i -: 8] = t[i];
        for (int c = 0; c < 4; c++) mx[127-32*c -: 32] = mix_col(sh[127-32*c -: 32], inverse);
        // middle decrypt round keys take invmixcolumns
        for (int c = 0; c < 4; c++) begin
            k[127-32*c -: 32] = (inverse && op == OP_FULL) ?
                mix_col(round_key[127-32*c -: 32], 1'b1) : round_key[127-32*c -: 32];
        end
        unique case (op)
            OP_ADD_ONLY: state_out = state_in ^ k;
            OP_FULL:     state_out = mx ^ k;
            OP_LAST:     state_out = sh ^ k;
            default:     state_out = state_in ^ k;
        endcase
    end
endmodule
`default_nettype wire

### hdl/aes128_block_cipher.sv
// aes-128 cipher top level: config port, sequencer, round unit, output register
`timescale 1ns / 1ps
`default_nettype none
// Encrypts or decrypts one 128-bit word with AES-128 under the key held in
// key_high (byte 0x00) and key_low (byte 0x08). After reset and after every
// key write the schedule is rebuilt one word per cycle, and s_tready stays low
// meanwhile. Each of the ROUND_COUNT+1 key additions of a word reads four
// schedule words, one per cycle, from the single read port of the key memory,
// whose read data is registered; then the shared round unit applies one round.
// After the last round the output register is loaded. The result waits in that
// register; the next word is taken once it has been delivered.
module aes128_block_cipher
    import aes_pkg::*;
#(
    parameter int ROUND_COUNT = 10
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // block_high [63:0], block_low [127:64]
    input  wire logic [127:0] s_tdata,
    // operation [0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_high [63:0], result_low [127:64]
    output logic [127:0]      m_tdata
);
    localparam int WORDS = 4 * (ROUND_COUNT + 1);
    localparam int AW = $clog2(WORDS);
    localparam int RW = $clog2(ROUND_COUNT + 1);
    localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
    localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;

    typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_ROUND, ST_OUT} state_t;

    state_t         state_reg;
    logic [63:0]    key_high_reg, key_low_reg;
    logic           kick_reg;
    logic [127:0]   st_reg, rk_reg, res_reg;
    logic           inv_reg;
    logic [RW-1:0]  rnd_reg;
    logic [2:0]     wc_reg;
    logic           m_valid_reg;
    logic           ks_busy;
    logic [31:0]    rd_data;
    logic [AW-1:0]  rd_addr;
    logic [RW-1:0]  key_rnd;
    logic [127:0]   rnd_out;
    round_op_t      op;
    logic           wr;

    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;

    // register read back
    always_comb begin
        unique case (paddr)
            ADDR_KEY_HIGH: prdata = key_high_reg;
            ADDR_KEY_LOW:  prdata = key_low_reg;
            default:       prdata = '0;
        endcase
    end

    // key registers; any key write restarts the schedule
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            kick_reg     <= 1'b1;
        end else begin
            kick_reg <= wr && (paddr == ADDR_KEY_HIGH || paddr == ADDR_KEY_LOW);
            if (wr && paddr == ADDR_KEY_HIGH) key_high_reg <= pwdata;
            if (wr && paddr == ADDR_KEY_LOW)  key_low_reg  <= pwdata;
        end
    end

    aes_key_sched #(.ROUND_COUNT(ROUND_COUNT)) u_ks (
        .aclk(aclk), .aresetn(aresetn), .start(kick_reg),
        .key({key_high_reg, key_low_reg}), .rd_addr(rd_addr),
        .rd_data(rd_data), .busy(ks_busy)
    );

    // key round runs backward for decrypt
    assign key_rnd = inv_reg ? RW'(ROUND_COUNT) - rnd_reg : rnd_reg;
    assign rd_addr = AW'({key_rnd, 2'b00}) + AW'(wc_reg[1:0]);

    always_comb begin
        if (rnd_reg == '0)                    op = OP_ADD_ONLY;
        else if (rnd_reg == RW'(ROUND_COUNT)) op = OP_LAST;
        else                                  op = OP_FULL;
    end

    aes_round u_rnd (
        .state_in(st_reg), .round_key(rk_reg), .inverse(inv_reg),
        .op(op), .state_out(rnd_out)
    );

    assign s_tready = (state_reg == ST_IDLE) && !ks_busy && !kick_reg && !m_valid_reg;

    // sequencer: per round fetch four key words, then apply it; after the last, load the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rnd_reg     <= '0;
            wc_reg      <= '0;
        end else begin
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        st_reg    <= {s_tdata[63:0], s_tdata[127:64]};
                        inv_reg   <= s_tuser;
                        rnd_reg   <= '0;
                        wc_reg    <= '0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    // read data arrives in the cycle after its address
                    if (wc_reg != 3'd0) rk_reg <= {rk_reg[95:0], rd_data};
                    wc_reg <= wc_reg + 1'b1;
                    if (wc_reg == 3'd4) state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    st_reg <= rnd_out;
                    wc_reg <= '0;
                    if (rnd_reg == RW'(ROUND_COUNT)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        rnd_reg   <= rnd_reg + 1'b1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_OUT: begin
                    res_reg     <= {st_reg[63:0], st_reg[127:64]};
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;
endmodule
`default_nettype wire

### hdl/aes_checker.sv
// port-level checks for the aes-128 cipher
`timescale 1ns / 1ps
`default_nettype none
module aes_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata
);
    // a held word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("word dropped");
    // no new word taken while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accepted with result pending");
    // a word just taken cannot finish at once
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid && !s_tready) else $error("latency");
endmodule

bind aes128_block_cipher aes_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
